/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/fci_pkg.sv */
// ---------------------------------------------------------------------------
// fci_pkg
// Types and codes shared by the fan curve interpolator modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fci_pkg;

  typedef enum logic [2:0] {
    ST_WRITE  = 3'd0,
    ST_EXACT  = 3'd1,
    ST_INTERP = 3'd2,
    ST_BELOW  = 3'd3,
    ST_ABOVE  = 3'd4,
    ST_EMPTY  = 3'd5
  } status_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_SCAN,
    S_SETTLE,
    S_EVAL,
    S_MUL,
    S_DIVST,
    S_DIV
  } state_e;

  typedef struct packed {
    logic load;
    logic wr_en;
    logic scan_rd;
    logic prep;
    logic mul_en;
    logic div_start;
    logic out_en;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic interp;
    logic div_done;
  } sts_t;

endpackage

/* hdl/fci_ctrl.sv */
// ---------------------------------------------------------------------------
// fci_ctrl
// Sequencer: accepts a word, steps the table scan, multiply and divide.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fci_ctrl
  import fci_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic op_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy,
  output logic done_o
);

  state_e state_q, state_d;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.out_en;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (op_i == OP_WRITE) begin
            cmd_o.wr_en = 1'b1;
            state_d     = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_RESP: begin
        cmd_o.out_en = 1'b1;
        state_d      = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_SETTLE;
        end
      end
      S_SETTLE: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.interp) begin
          cmd_o.prep = 1'b1;
          state_d    = S_MUL;
        end else begin
          cmd_o.out_en = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_DIVST;
      end
      S_DIVST: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.out_en = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

/* hdl/fci_div.sv */
// ---------------------------------------------------------------------------
// fci_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fci_div #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quotient_o,
  output logic             done_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             active_q;
  logic             done_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q    <= CNT_W'(DVD_W);
        active_q <= 1'b1;
      end else if (active_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (active_q) begin
      if (fits) begin
        rem_q <= DVS_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_q <= DVS_W'(trial);
      end
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

/* hdl/fci_dp.sv */
// ---------------------------------------------------------------------------
// fci_dp
// Breakpoint table, neighbor scan, interpolation multiply/divide, result regs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fci_dp
  import fci_pkg::*;
#(
  parameter int NUM_POINTS = 8,
  parameter int TEMP_BITS  = 16,
  parameter int SPEED_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        op_i,
  input  logic [2:0]  entry_index_i,
  input  logic        entry_valid_i,
  input  logic [15:0] entry_temp_i,
  input  logic [15:0] entry_speed_i,
  input  logic [15:0] query_temp_i,
  output logic [15:0] speed_o,
  output logic [2:0]  status_o
);

  localparam int IDX_W  = $clog2(NUM_POINTS);
  localparam int PROD_W = SPEED_BITS + TEMP_BITS;
  localparam logic [31:0] NP32 = NUM_POINTS;

  // table
  logic [TEMP_BITS-1:0]  temp_mem  [NUM_POINTS];
  logic [SPEED_BITS-1:0] speed_mem [NUM_POINTS];
  logic [NUM_POINTS-1:0] valid_q;
  logic [IDX_W-1:0]      wr_addr;
  logic                  in_range;

  // item
  logic                  op_q;
  logic [TEMP_BITS-1:0]  q_q;

  // scan
  logic [IDX_W-1:0]      cnt_q;
  logic                  rd_act_q;
  logic                  rd_v_q;
  logic [TEMP_BITS-1:0]  rd_t_q;
  logic [SPEED_BITS-1:0] rd_s_q;

  logic                  any_q;
  logic                  ex_hit_q;
  logic [SPEED_BITS-1:0] ex_s_q;
  logic                  lo_have_q, hi_have_q;
  logic [TEMP_BITS-1:0]  lo_t_q, hi_t_q;
  logic [SPEED_BITS-1:0] lo_s_q, hi_s_q;

  // arithmetic
  logic                  falling_q;
  logic [SPEED_BITS-1:0] mag_q;
  logic [TEMP_BITS-1:0]  dt_q;
  logic [TEMP_BITS-1:0]  span_q;
  logic [PROD_W-1:0]     prod_q;
  logic [PROD_W-1:0]     quot;
  logic                  div_done;
  logic [SPEED_BITS-1:0] quot_s;
  logic [SPEED_BITS-1:0] interp_s;

  // result
  logic [SPEED_BITS-1:0] res_s;
  status_e               res_st;
  logic [15:0]           speed_q;
  status_e               status_q;

  assign wr_addr  = IDX_W'(entry_index_i);
  assign in_range = (32'(entry_index_i) < NP32);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && in_range) begin
      temp_mem[wr_addr]  <= TEMP_BITS'(entry_temp_i);
      speed_mem[wr_addr] <= SPEED_BITS'(entry_speed_i);
    end
    if (cmd_i.scan_rd) begin
      rd_t_q <= temp_mem[cnt_q];
      rd_s_q <= speed_mem[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      cnt_q    <= '0;
      rd_act_q <= 1'b0;
      rd_v_q   <= 1'b0;
    end else begin
      if (cmd_i.wr_en && in_range) begin
        valid_q[wr_addr] <= entry_valid_i;
      end
      rd_act_q <= cmd_i.scan_rd;
      if (cmd_i.scan_rd) begin
        rd_v_q <= valid_q[cnt_q];
      end
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_i;
      q_q       <= TEMP_BITS'(query_temp_i);
      any_q     <= 1'b0;
      ex_hit_q  <= 1'b0;
      lo_have_q <= 1'b0;
      hi_have_q <= 1'b0;
    end else if (rd_act_q && rd_v_q) begin
      any_q <= 1'b1;
      if (rd_t_q == q_q && !ex_hit_q) begin
        ex_hit_q <= 1'b1;
        ex_s_q   <= rd_s_q;
      end
      if (rd_t_q < q_q && (!lo_have_q || rd_t_q > lo_t_q)) begin
        lo_have_q <= 1'b1;
        lo_t_q    <= rd_t_q;
        lo_s_q    <= rd_s_q;
      end
      if (rd_t_q > q_q && (!hi_have_q || rd_t_q < hi_t_q)) begin
        hi_have_q <= 1'b1;
        hi_t_q    <= rd_t_q;
        hi_s_q    <= rd_s_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      falling_q <= (hi_s_q < lo_s_q);
      mag_q     <= (hi_s_q < lo_s_q) ? (lo_s_q - hi_s_q) : (hi_s_q - lo_s_q);
      dt_q      <= q_q - lo_t_q;
      span_q    <= hi_t_q - lo_t_q;
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(dt_q);
    end
  end

  fci_div #(
    .DVD_W(PROD_W),
    .DVS_W(TEMP_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .quotient_o (quot),
    .done_o     (div_done)
  );

  // quotient never exceeds mag, so it fits the speed width
  assign quot_s   = SPEED_BITS'(quot);
  assign interp_s = falling_q ? (lo_s_q - quot_s) : (lo_s_q + quot_s);

  always_comb begin
    if (op_q == OP_WRITE) begin
      res_s  = '0;
      res_st = ST_WRITE;
    end else if (ex_hit_q) begin
      res_s  = ex_s_q;
      res_st = ST_EXACT;
    end else if (!any_q) begin
      res_s  = '0;
      res_st = ST_EMPTY;
    end else if (!lo_have_q) begin
      res_s  = hi_s_q;
      res_st = ST_BELOW;
    end else if (!hi_have_q) begin
      res_s  = lo_s_q;
      res_st = ST_ABOVE;
    end else begin
      res_s  = interp_s;
      res_st = ST_INTERP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_en) begin
      speed_q  <= 16'(res_s);
      status_q <= res_st;
    end
  end

  assign sts_o.scan_last = (cnt_q == IDX_W'(NUM_POINTS - 1));
  assign sts_o.interp    = !ex_hit_q && any_q && lo_have_q && hi_have_q;
  assign sts_o.div_done  = div_done;

  assign speed_o  = speed_q;
  assign status_o = status_q;

endmodule

/* hdl/fan_curve_interpolator_unit.sv */
// ---------------------------------------------------------------------------
// fan_curve_interpolator_unit
// Piecewise linear fan curve: breakpoint table writes and speed queries.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low; op_i selects a table
// write or a speed query. Each word gives exactly one result on speed_o and
// status_o, shown for one cycle with done_o; the receiver cannot stall, so
// the result must be captured in that cycle. A query reads the table through
// one memory port, one entry per cycle, before an exact hit or an
// end-of-curve answer is given; an interpolated answer adds a multiply and a
// one-bit-per-cycle divide over TEMP_BITS + SPEED_BITS quotient bits. busy
// stays high until the result is out.
`timescale 1ns / 1ps

module fan_curve_interpolator_unit
  import fci_pkg::*;
#(
  parameter int NUM_POINTS = 8,
  parameter int TEMP_BITS  = 16,
  parameter int SPEED_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [2:0]  entry_index_i,
  input  logic        entry_valid_i,
  input  logic [15:0] entry_temp_i,
  input  logic [15:0] entry_speed_i,
  input  logic [15:0] query_temp_i,
  output logic        done_o,
  output logic [15:0] speed_o,
  output logic [2:0]  status_o
);

  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  fci_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  fci_dp #(
    .NUM_POINTS (NUM_POINTS),
    .TEMP_BITS  (TEMP_BITS),
    .SPEED_BITS (SPEED_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .entry_valid_i (entry_valid_i),
    .entry_temp_i  (entry_temp_i),
    .entry_speed_i (entry_speed_i),
    .query_temp_i  (query_temp_i),
    .speed_o       (speed_o),
    .status_o      (status_o)
  );

  `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ASSERT_SAME(a_done_idle, done_o, !busy)
  `ASSERT_NEXT(a_done_single, done_o, !done_o)
  `ASSERT_SAME(a_write_zero, done_o && status_o == ST_WRITE, speed_o == 16'd0)

endmodule

/* sim/fan_curve_interpolator_unit_tb.sv */
// ---------------------------------------------------------------------------
// fan_curve_interpolator_unit_tb
// Self-checking bench for the fan curve interpolator: a directed table of
// breakpoint writes and speed queries, then random curves with queries
// aimed at breakpoints, their neighbors and the ends of the range.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fan_curve_interpolator_unit_tb;
  import fci_pkg::*;

  localparam int NPTS        = 8;
  localparam int RAND_WORDS  = 700;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct packed {
    op_e         op;
    logic [2:0]  idx;
    logic        vld;
    logic [15:0] et;
    logic [15:0] es;
    logic [15:0] qt;
    logic        fixed;
    logic [15:0] x_speed;
    status_e     x_status;
  } word_t;

  typedef struct packed {
    logic [15:0] speed;
    status_e     status;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        op_i = 1'b0;
  logic [2:0]  entry_index_i = '0;
  logic        entry_valid_i = 1'b0;
  logic [15:0] entry_temp_i = '0;
  logic [15:0] entry_speed_i = '0;
  logic [15:0] query_temp_i = '0;
  logic        done_o;
  logic [15:0] speed_o;
  logic [2:0]  status_o;

  logic [15:0] bp_temp  [NPTS];
  logic [15:0] bp_speed [NPTS];
  logic        bp_valid [NPTS];

  answer_t answers_due[$];
  int      fail_cnt = 0;
  int      cycle_cnt = 0;
  int      words_sent = 0;

  fan_curve_interpolator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .entry_valid_i (entry_valid_i),
    .entry_temp_i  (entry_temp_i),
    .entry_speed_i (entry_speed_i),
    .query_temp_i  (query_temp_i),
    .done_o        (done_o),
    .speed_o       (speed_o),
    .status_o      (status_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // directed rows; fixed = 1 carries a hand-written answer
  word_t dir_rows [20] = '{
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'd0,      1'b1, 16'd0,      ST_EMPTY},
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'hFFFF,   1'b1, 16'd0,      ST_EMPTY},
    '{OP_WRITE, 3'd0, 1'b1, 16'd0,      16'd100,    16'd0,      1'b1, 16'd0,      ST_WRITE},
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'd0,      1'b1, 16'd100,    ST_EXACT},
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'd50,     1'b1, 16'd100,    ST_ABOVE},
    '{OP_WRITE, 3'd7, 1'b1, 16'hFFFF,   16'hFFFF,   16'd0,      1'b1, 16'd0,      ST_WRITE},
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'hFFFF,   1'b1, 16'hFFFF,   ST_EXACT},
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'h8000,   1'b0, 16'd0,      ST_WRITE},
    '{OP_WRITE, 3'd3, 1'b1, 16'd1000,   16'd0,      16'd0,      1'b1, 16'd0,      ST_WRITE},
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'd500,    1'b0, 16'd0,      ST_WRITE},
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'd999,    1'b0, 16'd0,      ST_WRITE},
    '{OP_WRITE, 3'd0, 1'b0, 16'd0,      16'd100,    16'd0,      1'b1, 16'd0,      ST_WRITE},
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'd0,      1'b0, 16'd0,      ST_WRITE},
    '{OP_WRITE, 3'd5, 1'b1, 16'd1000,   16'd7777,   16'd0,      1'b1, 16'd0,      ST_WRITE},
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'd1000,   1'b0, 16'd0,      ST_WRITE},
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'd1001,   1'b0, 16'd0,      ST_WRITE},
    '{OP_WRITE, 3'd2, 1'b1, 16'h5555,   16'hAAAA,   16'd0,      1'b1, 16'd0,      ST_WRITE},
    '{OP_WRITE, 3'd4, 1'b1, 16'hAAAA,   16'h5555,   16'd0,      1'b1, 16'd0,      ST_WRITE},
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'h7FFF,   1'b0, 16'd0,      ST_WRITE},
    '{OP_QUERY, 3'd0, 1'b0, 16'd0,      16'd0,      16'd1,      1'b0, 16'd0,      ST_WRITE}
  };

  // curve lookup; updates the local breakpoint table on writes
  function automatic answer_t curve_lookup(input word_t w);
    answer_t     a;
    logic [15:0] lo_t, lo_s, hi_t, hi_s;
    logic        have_lo, have_hi, any_pt, falling;
    logic [63:0] mag, dt, span, quot;
    a.speed  = '0;
    a.status = ST_WRITE;
    have_lo = 1'b0;
    have_hi = 1'b0;
    any_pt  = 1'b0;
    lo_t = '0; lo_s = '0; hi_t = '0; hi_s = '0;
    if (w.op == OP_WRITE) begin
      bp_valid[w.idx] = w.vld;
      bp_temp[w.idx]  = w.et;
      bp_speed[w.idx] = w.es;
      return a;
    end
    for (int i = 0; i < NPTS; i++) begin
      if (bp_valid[i] && bp_temp[i] == w.qt) begin
        a.speed  = bp_speed[i];
        a.status = ST_EXACT;
        return a;
      end
    end
    for (int i = 0; i < NPTS; i++) begin
      if (bp_valid[i]) begin
        any_pt = 1'b1;
        if (bp_temp[i] < w.qt && (!have_lo || bp_temp[i] > lo_t)) begin
          lo_t = bp_temp[i];
          lo_s = bp_speed[i];
          have_lo = 1'b1;
        end
        if (bp_temp[i] > w.qt && (!have_hi || bp_temp[i] < hi_t)) begin
          hi_t = bp_temp[i];
          hi_s = bp_speed[i];
          have_hi = 1'b1;
        end
      end
    end
    if (!any_pt) begin
      a.status = ST_EMPTY;
    end else if (!have_lo) begin
      a.speed  = hi_s;
      a.status = ST_BELOW;
    end else if (!have_hi) begin
      a.speed  = lo_s;
      a.status = ST_ABOVE;
    end else begin
      falling = hi_s < lo_s;
      mag  = falling ? 64'(lo_s - hi_s) : 64'(hi_s - lo_s);
      dt   = 64'(w.qt - lo_t);
      span = 64'(hi_t - lo_t);
      quot = (mag * dt) / span;
      a.speed  = falling ? 16'(64'(lo_s) - quot) : 16'(64'(lo_s) + quot);
      a.status = ST_INTERP;
    end
    return a;
  endfunction

  task automatic send_word(input word_t w);
    answer_t a;
    if (words_sent < 250 || words_sent >= 400) begin
      while ($urandom_range(0, 99) < 26) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start         <= 1'b1;
    op_i          <= w.op;
    entry_index_i <= w.idx;
    entry_valid_i <= w.vld;
    entry_temp_i  <= w.et;
    entry_speed_i <= w.es;
    query_temp_i  <= w.qt;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    a = curve_lookup(w);
    if (w.fixed) begin
      a.speed  = w.x_speed;
      a.status = w.x_status;
    end
    answers_due.push_back(a);
    words_sent++;
  endtask

  task automatic send_write(input logic [2:0] idx, input logic vld,
                            input logic [15:0] t, input logic [15:0] s);
    word_t w;
    w = '{OP_WRITE, idx, vld, t, s, 16'($urandom), 1'b0, 16'd0, ST_WRITE};
    send_word(w);
  endtask

  task automatic send_query(input logic [15:0] qt);
    word_t w;
    w = '{OP_QUERY, 3'($urandom), 1'($urandom), 16'($urandom), 16'($urandom), qt,
          1'b0, 16'd0, ST_WRITE};
    send_word(w);
  endtask

  function automatic logic [15:0] pick_temp();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 31));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_query();
    logic [15:0] t;
    t = bp_temp[$urandom_range(0, NPTS - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2: return t;
      3:       return t + 16'd1;
      4:       return t - 16'd1;
      5:       return 16'd0;
      6:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni && done_o === 1'b1) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected word: speed %h status %0d", $time, speed_o, status_o);
        fail_cnt++;
      end else begin
        a = answers_due.pop_front();
        if (speed_o !== a.speed) begin
          $display("%0t: speed expected %h actual %h", $time, a.speed, speed_o);
          fail_cnt++;
        end
        if (status_o !== a.status) begin
          $display("%0t: status expected %0d actual %0d", $time, a.status, status_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int n_wr;
    int n_q;
    for (int i = 0; i < NPTS; i++) begin
      bp_temp[i]  = '0;
      bp_speed[i] = '0;
      bp_valid[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i]);

    // random curves: build some breakpoints, then query around them
    while (words_sent < RAND_WORDS + 20) begin
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < NPTS; i++) send_write(3'(i), 1'b0, pick_temp(), pick_speed());
      end
      n_wr = $urandom_range(1, NPTS);
      for (int i = 0; i < n_wr; i++) begin
        send_write(3'($urandom), ($urandom_range(0, 99) < 85), pick_temp(), pick_speed());
      end
      n_q = $urandom_range(5, 20);
      for (int i = 0; i < n_q; i++) send_query(pick_query());
    end
    start <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
